// ----- hw/rtl/refr_pkg.sv -----
// ----------------------------------------------------------------------------
// refr_pkg
// Types, widths and helper functions shared by the refraction direction unit.
// ----------------------------------------------------------------------------
package refr_pkg;

   localparam int FRAC_BITS = 30;
   localparam int ETA_FRAC  = 16;
   localparam int DIR_W     = 32;
   localparam int ETA_W     = 20;
   localparam int RES_W     = 40;
   localparam int HALF_W    = RES_W / 2;
   localparam int COS_W     = 36;
   localparam int PROD_W    = 2 * DIR_W;
   localparam int CN_W      = COS_W + DIR_W;
   localparam int EP_W      = ETA_W + RES_W;
   localparam int SQ_W      = 2 * RES_W;
   localparam int AD_W      = 52;
   localparam int D_W       = AD_W + 1;
   localparam int ROOT_W    = (AD_W + FRAC_BITS + 1) / 2;
   localparam int RAD_W     = 2 * ROOT_W;
   localparam int REM_W     = ROOT_W + 3;
   localparam int FULL_W    = ROOT_W + DIR_W;
   localparam int WIDE_W    = 48;

   localparam logic signed [COS_W-1:0] ONE_COS = COS_W'(1) << FRAC_BITS;
   localparam logic [D_W-1:0] ONE_D = D_W'(1) << FRAC_BITS;
   localparam logic signed [WIDE_W-1:0] RES_MAX =
      {{(WIDE_W-RES_W+1){1'b0}}, {(RES_W-1){1'b1}}};
   localparam logic signed [WIDE_W-1:0] RES_MIN =
      {{(WIDE_W-RES_W+1){1'b1}}, {(RES_W-1){1'b0}}};

   typedef logic [2:0][DIR_W-1:0] dir_vec_type;
   typedef logic [2:0][RES_W-1:0] res_vec_type;

   typedef struct packed {
      logic signed [DIR_W-1:0] incident_x;
      logic signed [DIR_W-1:0] incident_y;
      logic signed [DIR_W-1:0] incident_z;
      logic signed [DIR_W-1:0] normal_x;
      logic signed [DIR_W-1:0] normal_y;
      logic signed [DIR_W-1:0] normal_z;
      logic [ETA_W-1:0]        eta_ratio;
   } req_type;

   typedef struct packed {
      logic signed [RES_W-1:0] refracted_x;
      logic signed [RES_W-1:0] refracted_y;
      logic signed [RES_W-1:0] refracted_z;
   } rsp_type;

   typedef struct packed {
      dir_vec_type             u;
      dir_vec_type             n;
      logic [ETA_W-1:0]        eta;
      logic signed [COS_W-1:0] c;
   } cos_type;

   typedef struct packed {
      dir_vec_type n;
      res_vec_type perp;
   } perp_type;

   typedef struct packed {
      dir_vec_type     n;
      res_vec_type     perp;
      logic [AD_W-1:0] ad;
   } norm_type;

   typedef struct packed {
      dir_vec_type       n;
      res_vec_type       perp;
      logic [ROOT_W-1:0] root;
   } root_type;

   function automatic logic [DIR_W-1:0] mag_dir(input logic [DIR_W-1:0] v);
      return v[DIR_W-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic [RES_W-1:0] mag_res(input logic [RES_W-1:0] v);
      return v[RES_W-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic [WIDE_W-1:0] apply_sign(input logic neg,
                                                   input logic [WIDE_W-1:0] v);
      return neg ? (~v + 1'b1) : v;
   endfunction

   function automatic logic [RES_W-1:0] sat_res(input logic signed [WIDE_W-1:0] v);
      logic [RES_W-1:0] r;
      if (v > RES_MAX) begin
         r = RES_MAX[RES_W-1:0];
      end else if (v < RES_MIN) begin
         r = RES_MIN[RES_W-1:0];
      end else begin
         r = v[RES_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/refr_chan_if.sv -----
// ----------------------------------------------------------------------------
// refr_chan_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface refr_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/refraction_direction_unit.sv -----
// ----------------------------------------------------------------------------
// refraction_direction_unit
// Snell's law refraction of a fixed-point direction vector, fully pipelined.
//
//   channel   dir  payload                                   handshake
//   req_chan  in   incident_x/y/z, normal_x/y/z, eta_ratio   valid/ready
//   rsp_chan  out  refracted_x/y/z                           valid/ready
//
// One transfer per cycle sustained while the output is not stalled; stages:
// 2 cosine, 4 perp, 3 norm, 41 square root (one root bit per stage), 2 output.
// Reset clears the stage valid bits only.
// The whole pipe advances when the output register is empty or taken;
// a stalled output holds every stage.
// ----------------------------------------------------------------------------
module refraction_direction_unit (
   input logic         clock,
   input logic         reset,
   refr_chan_if.sink   req_chan,
   refr_chan_if.source rsp_chan
);
   import refr_pkg::*;

   logic     en;
   logic     cos_v, perp_v, norm_v, root_v, out_v;
   cos_type  cos_d;
   perp_type perp_d;
   norm_type norm_d;
   root_type root_d;
   rsp_type  out_d;

   assign en             = !out_v || rsp_chan.ready;
   assign req_chan.ready = en;
   assign rsp_chan.valid = out_v;
   assign rsp_chan.payload = out_d;

   refr_cos u_cos (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(req_chan.valid), .in_data(req_chan.payload),
      .out_valid(cos_v), .out_data(cos_d)
   );

   refr_perp u_perp (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(cos_v), .in_data(cos_d),
      .out_valid(perp_v), .out_data(perp_d)
   );

   refr_norm u_norm (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(perp_v), .in_data(perp_d),
      .out_valid(norm_v), .out_data(norm_d)
   );

   refr_sqrt u_sqrt (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(norm_v), .in_data(norm_d),
      .out_valid(root_v), .out_data(root_d)
   );

   refr_out u_out (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(root_v), .in_data(root_d),
      .out_valid(out_v), .out_data(out_d)
   );
endmodule

// ----- hw/rtl/refr_cos.sv -----
// ----------------------------------------------------------------------------
// refr_cos
// Two stages: products of incident and normal components, then their summed dot product as the clamped cosine.
// ----------------------------------------------------------------------------
module refr_cos (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  refr_pkg::req_type in_data,
   output logic              out_valid,
   output refr_pkg::cos_type out_data
);
   import refr_pkg::*;

   dir_vec_type               u_in, n_in;
   logic [2:0][PROD_W-1:0]    prod_in, prod_ff;
   logic [2:0]                neg_in, neg_ff;
   logic                      v1_ff;
   dir_vec_type               u_ff, n_ff;
   logic [ETA_W-1:0]          eta_ff;
   logic [2:0][COS_W-1:0]     term_in;
   logic signed [COS_W-1:0]   dot_in, c_in;
   logic                      v2_ff;
   cos_type                   c_ff;

   always_comb begin
      u_in = {in_data.incident_z, in_data.incident_y, in_data.incident_x};
      n_in = {in_data.normal_z, in_data.normal_y, in_data.normal_x};
      for (int i = 0; i < 3; i++) begin
         prod_in[i] = PROD_W'(mag_dir(u_in[i])) * PROD_W'(mag_dir(n_in[i]));
         neg_in[i]  = u_in[i][DIR_W-1] ^ n_in[i][DIR_W-1];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         term_in[i] = COS_W'(apply_sign(neg_ff[i], WIDE_W'(prod_ff[i] >> FRAC_BITS)));
      end
      dot_in = $signed(term_in[0]) + $signed(term_in[1]) + $signed(term_in[2]);
      c_in   = -dot_in;
      if (c_in > ONE_COS) begin
         c_in = ONE_COS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= prod_in;
         neg_ff   <= neg_in;
         u_ff     <= u_in;
         n_ff     <= n_in;
         eta_ff   <= in_data.eta_ratio;
         c_ff.u   <= u_ff;
         c_ff.n   <= n_ff;
         c_ff.eta <= eta_ff;
         c_ff.c   <= c_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = c_ff;
endmodule

// ----- hw/rtl/refr_perp.sv -----
// ----------------------------------------------------------------------------
// refr_perp
// Four stages: c*n, incident plus c*n, eta product, saturated perpendicular.
// ----------------------------------------------------------------------------
module refr_perp (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  refr_pkg::cos_type  in_data,
   output logic               out_valid,
   output refr_pkg::perp_type out_data
);
   import refr_pkg::*;

   logic [COS_W-1:0]       cmag;
   logic [2:0][CN_W-1:0]   cn_in, cn_ff;
   logic [2:0]             cneg_in, cneg_ff;
   logic                   v3_ff, v4_ff, v5_ff, v6_ff;
   dir_vec_type            u3_ff, n3_ff, n4_ff, n5_ff;
   logic [ETA_W-1:0]       eta3_ff, eta4_ff;
   res_vec_type            t_in, t_ff;
   logic [2:0][EP_W-1:0]   ep_in, ep_ff;
   logic [2:0]             tneg_ff;
   res_vec_type            perp_in;
   perp_type               p_ff;

   always_comb begin
      cmag = in_data.c[COS_W-1] ? (~in_data.c + 1'b1) : in_data.c;
      for (int i = 0; i < 3; i++) begin
         cn_in[i]   = CN_W'(cmag) * CN_W'(mag_dir(in_data.n[i]));
         cneg_in[i] = in_data.c[COS_W-1] ^ in_data.n[i][DIR_W-1];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         t_in[i] = RES_W'($signed(u3_ff[i]))
                 + RES_W'(apply_sign(cneg_ff[i], WIDE_W'(cn_ff[i] >> FRAC_BITS)));
         ep_in[i] = EP_W'(eta4_ff) * EP_W'(mag_res(t_ff[i]));
         perp_in[i] = sat_res($signed(apply_sign(tneg_ff[i],
                                                 WIDE_W'(ep_ff[i] >> ETA_FRAC))));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= in_valid;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cn_ff   <= cn_in;
         cneg_ff <= cneg_in;
         u3_ff   <= in_data.u;
         n3_ff   <= in_data.n;
         eta3_ff <= in_data.eta;
         t_ff    <= t_in;
         n4_ff   <= n3_ff;
         eta4_ff <= eta3_ff;
         ep_ff   <= ep_in;
         for (int i = 0; i < 3; i++) begin
            tneg_ff[i] <= t_ff[i][RES_W-1];
         end
         n5_ff     <= n4_ff;
         p_ff.n    <= n5_ff;
         p_ff.perp <= perp_in;
      end
   end

   assign out_valid = v6_ff;
   assign out_data  = p_ff;
endmodule

// ----- hw/rtl/refr_norm.sv -----
// ----------------------------------------------------------------------------
// refr_norm
// Three stages: split squares of perp, scaled squares, |1 - |perp|^2|.
// ----------------------------------------------------------------------------
module refr_norm (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  refr_pkg::perp_type in_data,
   output logic               out_valid,
   output refr_pkg::norm_type out_data
);
   import refr_pkg::*;

   res_vec_type            pm;
   res_vec_type            hh_in, hl_in, ll_in, hh_ff, hl_ff, ll_ff;
   logic                   v7_ff, v8_ff, v9_ff;
   dir_vec_type            n7_ff, n8_ff;
   res_vec_type            perp7_ff, perp8_ff;
   logic [2:0][SQ_W-1:0]   sq;
   logic [2:0][AD_W-1:0]   sqq_in, sqq_ff;
   logic [AD_W-1:0]        lsq;
   logic [D_W-1:0]         d;
   logic [AD_W-1:0]        ad_in;
   norm_type               q_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pm[i]    = mag_res(in_data.perp[i]);
         hh_in[i] = RES_W'(pm[i][RES_W-1:HALF_W]) * RES_W'(pm[i][RES_W-1:HALF_W]);
         hl_in[i] = RES_W'(pm[i][RES_W-1:HALF_W]) * RES_W'(pm[i][HALF_W-1:0]);
         ll_in[i] = RES_W'(pm[i][HALF_W-1:0]) * RES_W'(pm[i][HALF_W-1:0]);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq[i] = (SQ_W'(hh_ff[i]) << RES_W) + (SQ_W'(hl_ff[i]) << (HALF_W + 1))
               + SQ_W'(ll_ff[i]);
         sqq_in[i] = AD_W'(sq[i] >> FRAC_BITS);
      end
      lsq   = sqq_ff[0] + sqq_ff[1] + sqq_ff[2];
      d     = ONE_D - D_W'(lsq);
      ad_in = d[D_W-1] ? AD_W'(~d + 1'b1) : AD_W'(d);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
      end else if (en) begin
         v7_ff <= in_valid;
         v8_ff <= v7_ff;
         v9_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hh_ff     <= hh_in;
         hl_ff     <= hl_in;
         ll_ff     <= ll_in;
         n7_ff     <= in_data.n;
         perp7_ff  <= in_data.perp;
         sqq_ff    <= sqq_in;
         n8_ff     <= n7_ff;
         perp8_ff  <= perp7_ff;
         q_ff.n    <= n8_ff;
         q_ff.perp <= perp8_ff;
         q_ff.ad   <= ad_in;
      end
   end

   assign out_valid = v9_ff;
   assign out_data  = q_ff;
endmodule

// ----- hw/rtl/refr_sqrt.sv -----
// ----------------------------------------------------------------------------
// refr_sqrt
// Pipelined restoring square root, one root bit per stage.
// ----------------------------------------------------------------------------
module refr_sqrt (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  refr_pkg::norm_type in_data,
   output logic               out_valid,
   output refr_pkg::root_type out_data
);
   import refr_pkg::*;

   logic              vld_ff  [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];
   dir_vec_type       n_ff    [ROOT_W];
   res_vec_type       perp_ff [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic              v_prev;
      logic [REM_W-1:0]  rem_prev, rem4, trial;
      logic [ROOT_W-1:0] root_prev;
      logic [RAD_W-1:0]  rad_prev;
      dir_vec_type       n_prev;
      res_vec_type       perp_prev;
      logic              ge;

      if (k == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = RAD_W'(in_data.ad) << FRAC_BITS;
         assign n_prev    = in_data.n;
         assign perp_prev = in_data.perp;
      end else begin : g_next
         assign v_prev    = vld_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign n_prev    = n_ff[k-1];
         assign perp_prev = perp_ff[k-1];
      end

      assign rem4  = {rem_prev[REM_W-3:0], rad_prev[RAD_W-1-2*k -: 2]};
      assign trial = {1'b0, root_prev, 2'b01};
      assign ge    = (rem4 >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? (rem4 - trial) : rem4;
            root_ff[k] <= {root_prev[ROOT_W-2:0], ge};
            rad_ff[k]  <= rad_prev;
            n_ff[k]    <= n_prev;
            perp_ff[k] <= perp_prev;
         end
      end
   end

   always_comb begin
      out_valid     = vld_ff[ROOT_W-1];
      out_data.n    = n_ff[ROOT_W-1];
      out_data.perp = perp_ff[ROOT_W-1];
      out_data.root = root_ff[ROOT_W-1];
   end
endmodule

// ----- hw/rtl/refr_out.sv -----
// ----------------------------------------------------------------------------
// refr_out
// Two stages: root times normal in partial products, then saturated sum.
// ----------------------------------------------------------------------------
module refr_out (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  refr_pkg::root_type in_data,
   output logic               out_valid,
   output refr_pkg::rsp_type  out_data
);
   import refr_pkg::*;

   logic [2:0][PROD_W-1:0] lo_in, lo_ff;
   logic [2:0][ROOT_W-1:0] hi_in, hi_ff;
   logic [2:0]             nneg_ff;
   res_vec_type            perp_ff;
   logic                   va_ff, vb_ff;
   logic [2:0][FULL_W-1:0] full;
   logic [2:0][WIDE_W-1:0] m;
   res_vec_type            res_in;
   rsp_type                rsp_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lo_in[i] = PROD_W'(in_data.root[DIR_W-1:0]) * PROD_W'(mag_dir(in_data.n[i]));
         hi_in[i] = ROOT_W'(in_data.root[ROOT_W-1:DIR_W]) * ROOT_W'(mag_dir(in_data.n[i]));
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         full[i]   = (FULL_W'(hi_ff[i]) << DIR_W) + FULL_W'(lo_ff[i]);
         m[i]      = apply_sign(!nneg_ff[i], WIDE_W'(full[i] >> FRAC_BITS));
         res_in[i] = sat_res($signed(WIDE_W'($signed(perp_ff[i]))) + $signed(m[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         perp_ff <= in_data.perp;
         for (int i = 0; i < 3; i++) begin
            nneg_ff[i] <= in_data.n[i][DIR_W-1];
         end
         rsp_ff.refracted_x <= res_in[0];
         rsp_ff.refracted_y <= res_in[1];
         rsp_ff.refracted_z <= res_in[2];
      end
   end

   assign out_valid = vb_ff;
   assign out_data  = rsp_ff;
endmodule

// ----- hw/rtl/refr_checker.sv -----
// ----------------------------------------------------------------------------
// refr_checker
// Port-level checks of the refraction direction unit, bound to the top level.
// ----------------------------------------------------------------------------
module refr_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input refr_pkg::rsp_type rsp_payload
);
   import refr_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while output stalled");

endmodule

bind refraction_direction_unit refr_checker u_refr_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_payload(rsp_chan.payload)
);
